### hw/rtl/igd_pkg.sv
// ----------------------------------------------------------------------------
// igd_pkg
// Shared constants, types and tables for the wrist-raise gesture detector.
// ----------------------------------------------------------------------------
package igd_pkg;

	// Ring of recent samples and the averaging window.
	localparam int HIST_DEPTH = 16;
	localparam int PTR_W      = $clog2(HIST_DEPTH);
	localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
	localparam int WIN_LEN    = 8;
	localparam int WIN_LOG    = $clog2(WIN_LEN);
	localparam int CNT_W      = $clog2(WIN_LEN + 1);
	localparam int OLD_BACK   = (HIST_DEPTH - (WIN_LEN % HIST_DEPTH)) % HIST_DEPTH;

	// Datapath widths.
	localparam int SAMP_W = 16;
	localparam int SUM_W  = SAMP_W + WIN_LOG + 1;
	localparam int DIFF_W = SAMP_W + 1;
	localparam int SQ_W   = 2 * DIFF_W + WIN_LOG + 2;
	localparam int VAR_W  = 31;
	localparam int CFG_W  = 31;
	localparam int IDX_W  = 3;
	localparam int ROLL_W = 9;

	// Angle arithmetic in degrees with 16 fraction bits.
	localparam int XY_W       = 34;
	localparam int ANG_W      = 27;
	localparam int PRESCALE   = 14;
	localparam int FRAC_BITS  = 16;
	localparam int CORDIC_N   = 16;
	localparam int STEP_W     = $clog2(CORDIC_N);
	localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180 * 65536);
	localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(360 * 65536);
	localparam logic [ANG_W-1:0] ROUND_HALF = ANG_W'(32768);
	localparam logic [VAR_W-1:0] VAR_MAX = VAR_W'(1073741824);

	localparam int IN_W  = 48;
	localparam int OUT_W = 224;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_X_TILT   = 3'd0,
		REG_Y_ORIENT = 3'd1,
		REG_Y_UNSTAB = 3'd2,
		REG_VAR_LIM  = 3'd3,
		REG_ROLL_LIM = 3'd4
	} reg_idx_t;

	// Reason codes.
	localparam logic [2:0] RSN_WARMUP   = 3'd0;
	localparam logic [2:0] RSN_X_TILT   = 3'd1;
	localparam logic [2:0] RSN_UNSTABLE = 3'd2;
	localparam logic [2:0] RSN_Y_ORIENT = 3'd3;
	localparam logic [2:0] RSN_ROLL     = 3'd4;
	localparam logic [2:0] RSN_DETECT   = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SUM_NEW,
		ST_SQ_NEW,
		ST_SUM_OLD,
		ST_COR_NEW,
		ST_COR_OLD,
		ST_NORM
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             accept;
		logic             rd_en;
		logic [PTR_W-1:0] rd_off;
		logic             sum_clr;
		logic             sum_en;
		logic             sq_clr;
		logic             sq_en;
		logic             latch_new;
		logic             cor_start;
		logic             cor_old;
		logic             keep_ang;
		logic             load_diff;
		logic             norm_step;
		logic             load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic cor_done;
		logic in_range;
	} sts_t;

	// Arctangent of 2^-i in degrees, 16 fraction bits.
	function automatic logic signed [ANG_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
		logic signed [ANG_W-1:0] r;
		case (i)
			4'd0:    r = 27'sd2949120;
			4'd1:    r = 27'sd1740967;
			4'd2:    r = 27'sd919879;
			4'd3:    r = 27'sd466945;
			4'd4:    r = 27'sd234379;
			4'd5:    r = 27'sd117304;
			4'd6:    r = 27'sd58666;
			4'd7:    r = 27'sd29335;
			4'd8:    r = 27'sd14668;
			4'd9:    r = 27'sd7334;
			4'd10:   r = 27'sd3667;
			4'd11:   r = 27'sd1833;
			4'd12:   r = 27'sd917;
			4'd13:   r = 27'sd458;
			4'd14:   r = 27'sd229;
			default: r = 27'sd115;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/igd_cordic.sv
// ----------------------------------------------------------------------------
// igd_cordic
// Iterative vectoring CORDIC: atan2(num, den) in degrees, one step a cycle.
// ----------------------------------------------------------------------------
module igd_cordic (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [igd_pkg::SAMP_W-1:0]     num,
	input  logic signed [igd_pkg::SAMP_W-1:0]     den,
	output logic                                  done,
	output logic signed [igd_pkg::ANG_W-1:0]      angle
);

	logic                                busy_q;
	logic                                done_q;
	logic                                zero_q;
	logic [igd_pkg::STEP_W-1:0]          step_q;
	logic signed [igd_pkg::XY_W-1:0]     x_q;
	logic signed [igd_pkg::XY_W-1:0]     y_q;
	logic signed [igd_pkg::ANG_W-1:0]    ang_q;
	logic signed [igd_pkg::XY_W-1:0]     x_init;
	logic signed [igd_pkg::XY_W-1:0]     y_init;
	logic signed [igd_pkg::XY_W-1:0]     xs;
	logic signed [igd_pkg::XY_W-1:0]     ys;
	logic                                last_step;

	// Operands scaled up so the shifts keep precision.
	assign x_init    = igd_pkg::XY_W'(den) <<< igd_pkg::PRESCALE;
	assign y_init    = igd_pkg::XY_W'(num) <<< igd_pkg::PRESCALE;
	assign xs        = x_q >>> step_q;
	assign ys        = y_q >>> step_q;
	assign last_step = (step_q == igd_pkg::STEP_W'(igd_pkg::CORDIC_N - 1));

	// Control: busy flag, step count and a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && last_step;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Rotation step; a negative x operand is folded into the right half plane.
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (num == '0) && (den == '0);
			if (den < 0) begin
				x_q   <= -x_init;
				y_q   <= -y_init;
				ang_q <= (num >= 0) ? igd_pkg::HALF_TURN : -igd_pkg::HALF_TURN;
			end else begin
				x_q   <= x_init;
				y_q   <= y_init;
				ang_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q   <= x_q + ys;
				y_q   <= y_q - xs;
				ang_q <= ang_q + igd_pkg::atan_lut(step_q);
			end else begin
				x_q   <= x_q - ys;
				y_q   <= y_q + xs;
				ang_q <= ang_q - igd_pkg::atan_lut(step_q);
			end
		end
	end

	assign done  = done_q;
	assign angle = zero_q ? '0 : ang_q;

endmodule

### hw/rtl/igd_ctrl.sv
// ----------------------------------------------------------------------------
// igd_ctrl
// Sequencer: walks the windows, runs the angle unit and hands off the result.
// ----------------------------------------------------------------------------
module igd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  igd_pkg::sts_t  sts,
	output igd_pkg::cmd_t  cmd
);

	igd_pkg::state_t             state_q, state_d;
	logic [igd_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic                        out_valid_q;
	logic                        walk_last;

	assign walk_last = (cnt_q == igd_pkg::CNT_W'(igd_pkg::WIN_LEN));

	// State, walk counter and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= igd_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cnt_d   = '0;
		cmd     = '0;
		unique case (state_q)
			igd_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = igd_pkg::ST_CHECK;
				end
			end
			igd_pkg::ST_CHECK: begin
				// Warmup items go straight to the output register.
				if (!sts.full) begin
					if (!out_valid_q || m_tready) begin
						cmd.load_out = 1'b1;
						state_d      = igd_pkg::ST_IDLE;
					end
				end else begin
					state_d = igd_pkg::ST_SUM_NEW;
				end
			end
			igd_pkg::ST_SUM_NEW, igd_pkg::ST_SQ_NEW, igd_pkg::ST_SUM_OLD: begin
				// One read a cycle; data is accumulated in the cycle after its read.
				cmd.rd_en  = !walk_last;
				cmd.rd_off = (state_q == igd_pkg::ST_SUM_OLD)
					? igd_pkg::PTR_W'(igd_pkg::OLD_BACK + cnt_q)
					: igd_pkg::PTR_W'(cnt_q);
				if (state_q == igd_pkg::ST_SQ_NEW) begin
					cmd.sq_clr = (cnt_q == '0);
					cmd.sq_en  = (cnt_q != '0);
				end else begin
					cmd.sum_clr = (cnt_q == '0);
					cmd.sum_en  = (cnt_q != '0);
				end
				if (walk_last) begin
					unique case (state_q)
						igd_pkg::ST_SUM_NEW: state_d = igd_pkg::ST_SQ_NEW;
						igd_pkg::ST_SQ_NEW: begin
							cmd.latch_new = 1'b1;
							state_d       = igd_pkg::ST_SUM_OLD;
						end
						default: state_d = igd_pkg::ST_COR_NEW;
					endcase
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			igd_pkg::ST_COR_NEW: begin
				cmd.cor_start = (cnt_q == '0);
				cnt_d         = igd_pkg::CNT_W'(1);
				if (sts.cor_done) begin
					cmd.keep_ang = 1'b1;
					cnt_d        = '0;
					state_d      = igd_pkg::ST_COR_OLD;
				end
			end
			igd_pkg::ST_COR_OLD: begin
				cmd.cor_old   = 1'b1;
				cmd.cor_start = (cnt_q == '0);
				cnt_d         = igd_pkg::CNT_W'(1);
				if (sts.cor_done) begin
					cmd.load_diff = 1'b1;
					cnt_d         = '0;
					state_d       = igd_pkg::ST_NORM;
				end
			end
			igd_pkg::ST_NORM: begin
				// Bring the angle change into half a turn, then hand off.
				if (!sts.in_range) begin
					cmd.norm_step = 1'b1;
				end else if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = igd_pkg::ST_IDLE;
				end
			end
			default: state_d = igd_pkg::ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == igd_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;

endmodule

### hw/rtl/igd_datapath.sv
// ----------------------------------------------------------------------------
// igd_datapath
// Sample ring, window accumulators, angle unit, checks and output register.
// ----------------------------------------------------------------------------
module igd_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [igd_pkg::IN_W-1:0]      s_tdata,
	input  logic                          cfg_we,
	input  logic [igd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [igd_pkg::CFG_W-1:0]     cfg_data,
	input  igd_pkg::cmd_t                 cmd,
	output igd_pkg::sts_t                 sts,
	output logic [igd_pkg::OUT_W-1:0]     m_tdata
);

	localparam int SW = igd_pkg::SAMP_W;

	// Configuration registers.
	logic [14:0]                     x_tilt_q;
	logic signed [SW-1:0]            y_orient_q;
	logic signed [SW-1:0]            y_unstab_q;
	logic [igd_pkg::VAR_W-1:0]       var_lim_q;
	logic signed [igd_pkg::ROLL_W-1:0] roll_lim_q;

	// Ring and counters.
	logic [igd_pkg::IN_W-1:0]        ring_mem [igd_pkg::HIST_DEPTH];
	logic [igd_pkg::IN_W-1:0]        rd_data_q;
	logic [igd_pkg::PTR_W-1:0]       head_q;
	logic [igd_pkg::FILL_W-1:0]      fill_q;
	logic [31:0]                     seen_q;

	// Accumulators and latched results.
	logic signed [igd_pkg::SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic [igd_pkg::SQ_W-1:0]         sq_x_q, sq_y_q, sq_z_q;
	logic signed [SW-1:0]             mean_x, mean_y, mean_z;
	logic signed [SW-1:0]             mn_x_q, mn_y_q, mn_z_q;
	logic signed [igd_pkg::DIFF_W-1:0] d_x, d_y, d_z;
	logic signed [2*igd_pkg::DIFF_W-1:0] p_x, p_y, p_z;
	logic signed [igd_pkg::ANG_W-1:0] ang_n_q;
	logic signed [igd_pkg::ANG_W-1:0] diff_q;
	logic signed [igd_pkg::ANG_W-1:0] cor_angle;
	logic                             cor_done;
	logic signed [SW-1:0]             cor_num, cor_den;

	// Result side.
	logic [igd_pkg::VAR_W-1:0]        var_x, var_y, var_z;
	logic [igd_pkg::ANG_W-1:0]        mag, mag_rnd;
	logic signed [igd_pkg::ROLL_W-1:0] roll;
	logic [SW:0]                      abs_mx;
	logic [2:0]                       reason;
	logic [igd_pkg::OUT_W-1:0]        out_d;
	logic [igd_pkg::OUT_W-1:0]        out_q;

	// Truncating-toward-zero mean of a window sum.
	function automatic logic signed [SW-1:0] win_mean(input logic signed [igd_pkg::SUM_W-1:0] s);
		logic signed [igd_pkg::SUM_W-1:0] b;
		b = (s < 0) ? s + igd_pkg::SUM_W'(igd_pkg::WIN_LEN - 1) : s;
		return SW'(b >>> igd_pkg::WIN_LOG);
	endfunction

	// Population variance with saturation.
	function automatic logic [igd_pkg::VAR_W-1:0] win_var(input logic [igd_pkg::SQ_W-1:0] q);
		logic [igd_pkg::SQ_W-1:0] v;
		v = q >> igd_pkg::WIN_LOG;
		return (v > igd_pkg::SQ_W'(igd_pkg::VAR_MAX)) ? igd_pkg::VAR_MAX
			: igd_pkg::VAR_W'(v);
	endfunction

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_tilt_q   <= 15'd384;
			y_orient_q <= -16'sd64;
			y_unstab_q <= -16'sd724;
			var_lim_q  <= 31'd3136;
			roll_lim_q <= -9'sd45;
		end else if (cfg_we) begin
			unique case (cfg_index)
				igd_pkg::REG_X_TILT:   x_tilt_q   <= cfg_data[14:0];
				igd_pkg::REG_Y_ORIENT: y_orient_q <= cfg_data[SW-1:0];
				igd_pkg::REG_Y_UNSTAB: y_unstab_q <= cfg_data[SW-1:0];
				igd_pkg::REG_VAR_LIM:  var_lim_q  <= cfg_data;
				igd_pkg::REG_ROLL_LIM: roll_lim_q <= cfg_data[igd_pkg::ROLL_W-1:0];
				default: ;
			endcase
		end
	end

	// Head pointer, fill level and item count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			seen_q <= '0;
		end else if (cmd.accept) begin
			head_q <= head_q + 1'b1;
			seen_q <= seen_q + 32'd1;
			if (fill_q != igd_pkg::FILL_W'(igd_pkg::HIST_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Ring memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ring_mem[head_q + 1'b1] <= s_tdata;
		end
		if (cmd.rd_en) begin
			rd_data_q <= ring_mem[head_q - cmd.rd_off];
		end
	end

	// Window sums.
	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
		end else if (cmd.sum_en) begin
			sum_x_q <= sum_x_q + igd_pkg::SUM_W'($signed(rd_data_q[SW-1:0]));
			sum_y_q <= sum_y_q + igd_pkg::SUM_W'($signed(rd_data_q[2*SW-1:SW]));
			sum_z_q <= sum_z_q + igd_pkg::SUM_W'($signed(rd_data_q[3*SW-1:2*SW]));
		end
	end

	assign mean_x = win_mean(sum_x_q);
	assign mean_y = win_mean(sum_y_q);
	assign mean_z = win_mean(sum_z_q);

	// Squared deviations from the mean, one multiplier per axis.
	assign d_x = igd_pkg::DIFF_W'($signed(rd_data_q[SW-1:0])) - igd_pkg::DIFF_W'(mean_x);
	assign d_y = igd_pkg::DIFF_W'($signed(rd_data_q[2*SW-1:SW])) - igd_pkg::DIFF_W'(mean_y);
	assign d_z = igd_pkg::DIFF_W'($signed(rd_data_q[3*SW-1:2*SW])) - igd_pkg::DIFF_W'(mean_z);

	// Full-width products so no square is cut short.
	assign p_x = d_x * d_x;
	assign p_y = d_y * d_y;
	assign p_z = d_z * d_z;

	always_ff @(posedge clk) begin
		if (cmd.sq_clr) begin
			sq_x_q <= '0;
			sq_y_q <= '0;
			sq_z_q <= '0;
		end else if (cmd.sq_en) begin
			sq_x_q <= sq_x_q + igd_pkg::SQ_W'($unsigned(p_x));
			sq_y_q <= sq_y_q + igd_pkg::SQ_W'($unsigned(p_y));
			sq_z_q <= sq_z_q + igd_pkg::SQ_W'($unsigned(p_z));
		end
	end

	// Newest-window means are held while the oldest window is summed.
	always_ff @(posedge clk) begin
		if (cmd.latch_new) begin
			mn_x_q <= mean_x;
			mn_y_q <= mean_y;
			mn_z_q <= mean_z;
		end
	end

	assign cor_num = cmd.cor_old ? mean_y : mn_y_q;
	assign cor_den = cmd.cor_old ? mean_z : mn_z_q;

	igd_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cor_start),
		.num    (cor_num),
		.den    (cor_den),
		.done   (cor_done),
		.angle  (cor_angle)
	);

	// Angle of the newest window, then the change and its wrap into half a turn.
	always_ff @(posedge clk) begin
		if (cmd.keep_ang) begin
			ang_n_q <= cor_angle;
		end
		if (cmd.load_diff) begin
			diff_q <= ang_n_q - cor_angle;
		end else if (cmd.norm_step) begin
			diff_q <= (diff_q > igd_pkg::HALF_TURN) ? diff_q - igd_pkg::FULL_TURN
				: diff_q + igd_pkg::FULL_TURN;
		end
	end

	assign sts = '{
		full:     (fill_q == igd_pkg::FILL_W'(igd_pkg::HIST_DEPTH)),
		cor_done: cor_done,
		in_range: (diff_q <= igd_pkg::HALF_TURN) && (diff_q >= -igd_pkg::HALF_TURN)
	};

	// Round to whole degrees, half away from zero.
	assign mag     = (diff_q < 0) ? $unsigned(-diff_q) : $unsigned(diff_q);
	assign mag_rnd = (mag + igd_pkg::ROUND_HALF) >> igd_pkg::FRAC_BITS;
	assign roll    = (diff_q < 0) ? -igd_pkg::ROLL_W'($signed(mag_rnd))
		: igd_pkg::ROLL_W'($signed(mag_rnd));

	assign var_x  = win_var(sq_x_q);
	assign var_y  = win_var(sq_y_q);
	assign var_z  = win_var(sq_z_q);
	assign abs_mx = (mn_x_q < 0) ? $unsigned(-(SW+1)'(mn_x_q)) : $unsigned((SW+1)'(mn_x_q));

	// Ordered threshold checks.
	always_comb begin
		if (abs_mx > (SW+1)'(x_tilt_q)) begin
			reason = igd_pkg::RSN_X_TILT;
		end else if ((var_y > var_lim_q) || ((mn_y_q < y_unstab_q) && (var_z > var_lim_q))) begin
			reason = igd_pkg::RSN_UNSTABLE;
		end else if (mn_y_q > y_orient_q) begin
			reason = igd_pkg::RSN_Y_ORIENT;
		end else if (roll >= roll_lim_q) begin
			reason = igd_pkg::RSN_ROLL;
		end else begin
			reason = igd_pkg::RSN_DETECT;
		end
	end

	// Result word; warmup items carry only the count and the warmup reason code.
	always_comb begin
		out_d       = '0;
		out_d[35:4] = seen_q;
		out_d[3:1]  = igd_pkg::RSN_WARMUP;
		if (sts.full) begin
			out_d[0]       = (reason == igd_pkg::RSN_DETECT);
			out_d[3:1]     = reason;
			out_d[51:36]   = mn_x_q;
			out_d[67:52]   = mn_y_q;
			out_d[83:68]   = mn_z_q;
			out_d[99:84]   = mean_y;
			out_d[115:100] = mean_z;
			out_d[146:116] = var_x;
			out_d[177:147] = var_y;
			out_d[208:178] = var_z;
			out_d[217:209] = roll;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= out_d;
		end
	end

	assign m_tdata = out_q;

endmodule

### hw/rtl/imu_raise_gesture_detector.sv
// ----------------------------------------------------------------------------
// imu_raise_gesture_detector
// Wrist-raise detector over a ring of recent 3-axis accelerometer samples.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents (lowest bit first)
// s_*     | in        | sample_x, sample_y, sample_z
// m_*     | out       | raise_flag, reason_code, sample_total, five means,
//         |           | three variances, roll_change_deg
// cfg_*   | in        | register writes, index 0..4
//
// A warmup item is loaded into the output register from the check state that
// follows its accept, once that register is free. A full item passes the check
// state, three window walks over the single ring read port, two runs of the
// iterative angle unit, at most one angle wrap step and a load into the output
// register; the next item can be accepted in the cycle after that load.
// One item is in work at a time; s_tready is high only while idle.
// A finished result waits in the output register; a stalled m_tready holds
// the next result until the register frees. Reset is asynchronous.
module imu_raise_gesture_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// sample_x, sample_y, sample_z
	input  logic [igd_pkg::IN_W-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// raise_flag, reason_code, sample_total, mean_x_now, mean_y_now,
	// mean_z_now, mean_y_old, mean_z_old, var_x_now, var_y_now, var_z_now,
	// roll_change_deg, zero fill
	output logic [igd_pkg::OUT_W-1:0]     m_tdata,
	input  logic                          cfg_we,
	input  logic [igd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [igd_pkg::CFG_W-1:0]     cfg_data
);

	igd_pkg::cmd_t cmd;
	igd_pkg::sts_t sts;

	igd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	igd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.m_tdata   (m_tdata)
	);

endmodule

### hw/rtl/igd_checker.sv
// ----------------------------------------------------------------------------
// igd_checker
// Port-level checks for the gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
module igd_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [igd_pkg::OUT_W-1:0]     m_tdata
);

	// One item at a time: after an accept the input side closes.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in work");

	// Reason codes stay within the defined set.
	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:1] <= igd_pkg::RSN_DETECT))
		else $error("reason code out of range");

	// The raise flag is set exactly for a detection.
	a_raise: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == igd_pkg::RSN_DETECT)))
		else $error("raise flag disagrees with reason code");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind imu_raise_gesture_detector igd_checker u_igd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
